@@ sv/deq_pkg.sv @@
// Shared constants, codes, types and index helper for the double-ended queue.
// Depends on nothing; deq_ctrl and the top level refer to it by scoped names.
package deq_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int VAL_W      = 32;   // width of the value ports
   localparam int TOTAL_W    = 5;    // width of the entry total port

   localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [2:0] MODE_PUSH_REAR  = 3'd1;
   localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
   localparam logic [2:0] MODE_POP_REAR   = 3'd3;
   localparam logic [2:0] MODE_PEEK       = 3'd4;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_POP_EMPTY  = 2'd1;
   localparam logic [1:0] STATUS_PUSH_FULL  = 2'd2;

   // Storage access issued in the cycle a word is accepted.
   typedef struct packed {
      logic                  wr_en;
      logic [IDX_W-1:0]      wr_addr;
      logic [DATA_WIDTH-1:0] wr_data;
      logic [IDX_W-1:0]      pop_addr;
      logic [IDX_W-1:0]      front_addr;
   } mem_cmd_type;

   // Response stage: everything the result needs beside the read data.
   typedef struct packed {
      logic                  valid;
      logic [1:0]            status;
      logic [CNT_W-1:0]      count;
      logic                  pop_hit;
      logic                  front_from_push;
      logic [DATA_WIDTH-1:0] push_data;
   } rsp_ctl_type;

   // (base + off) mod DEPTH, for sums known to stay below 2 * DEPTH.
   function automatic logic [IDX_W-1:0] wrap_add(logic [IDX_W-1:0] base,
                                                 logic [CNT_W-1:0] off);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
      if (sum >= (CNT_W+1)'(DEPTH)) begin
         sum = sum - (CNT_W+1)'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

@@ sv/deq_ram.sv @@
// Generic single-write, dual-read RAM with registered read data.
// Depends on nothing.
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

@@ sv/deq_ctrl.sv @@
// Queue control: front index and entry count, storage commands and the
// response stage. Depends on deq_pkg.
module deq_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [2:0]                    req_mode,
   input  logic [deq_pkg::DATA_WIDTH-1:0] req_data,
   output deq_pkg::mem_cmd_type          mem_cmd,
   output deq_pkg::rsp_ctl_type          rsp_ctl
);

   logic [deq_pkg::IDX_W-1:0] front_ff, front_in;
   logic [deq_pkg::CNT_W-1:0] count_ff, count_in;
   logic                      busy_ff;
   deq_pkg::rsp_ctl_type      rsp_ff, rsp_in;
   logic                      accept;
   logic                      full;
   logic                      empty;

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;
   assign full   = (count_ff == deq_pkg::CNT_W'(deq_pkg::DEPTH));
   assign empty  = (count_ff == '0);

   always_comb begin
      front_in = front_ff;
      count_in = count_ff;

      mem_cmd.wr_en      = 1'b0;
      mem_cmd.wr_addr    = front_ff;
      mem_cmd.wr_data    = req_data;
      mem_cmd.pop_addr   = front_ff;
      mem_cmd.front_addr = front_ff;

      rsp_in.valid           = accept;
      rsp_in.status          = deq_pkg::STATUS_OK;
      rsp_in.pop_hit         = 1'b0;
      rsp_in.front_from_push = 1'b0;
      rsp_in.push_data       = req_data;

      case (req_mode)
         deq_pkg::MODE_PUSH_FRONT: begin
            if (full) begin
               rsp_in.status = deq_pkg::STATUS_PUSH_FULL;
            end else begin
               front_in = deq_pkg::wrap_add(front_ff,
                                            deq_pkg::CNT_W'(deq_pkg::DEPTH - 1));
               count_in = count_ff + deq_pkg::CNT_W'(1);
               mem_cmd.wr_en   = accept;
               mem_cmd.wr_addr = front_in;
               rsp_in.front_from_push = 1'b1;
            end
         end
         deq_pkg::MODE_PUSH_REAR: begin
            if (full) begin
               rsp_in.status = deq_pkg::STATUS_PUSH_FULL;
            end else begin
               count_in = count_ff + deq_pkg::CNT_W'(1);
               mem_cmd.wr_en   = accept;
               mem_cmd.wr_addr = deq_pkg::wrap_add(front_ff, count_ff);
               rsp_in.front_from_push = empty;
            end
         end
         deq_pkg::MODE_POP_FRONT: begin
            if (empty) begin
               rsp_in.status = deq_pkg::STATUS_POP_EMPTY;
            end else begin
               front_in = deq_pkg::wrap_add(front_ff, deq_pkg::CNT_W'(1));
               count_in = count_ff - deq_pkg::CNT_W'(1);
               mem_cmd.pop_addr   = front_ff;
               mem_cmd.front_addr = front_in;
               rsp_in.pop_hit     = 1'b1;
            end
         end
         deq_pkg::MODE_POP_REAR: begin
            if (empty) begin
               rsp_in.status = deq_pkg::STATUS_POP_EMPTY;
            end else begin
               count_in = count_ff - deq_pkg::CNT_W'(1);
               mem_cmd.pop_addr = deq_pkg::wrap_add(front_ff, count_in);
               rsp_in.pop_hit   = 1'b1;
            end
         end
         default: begin
            // peek and unused codes: read the front, change nothing
         end
      endcase

      rsp_in.count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         busy_ff      <= 1'b1;
         rsp_ff.valid <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         rsp_ff.valid <= rsp_in.valid;
         if (accept) begin
            front_ff <= front_in;
            count_ff <= count_in;
         end
      end
      if (accept) begin
         rsp_ff.status          <= rsp_in.status;
         rsp_ff.count           <= rsp_in.count;
         rsp_ff.pop_hit         <= rsp_in.pop_hit;
         rsp_ff.front_from_push <= rsp_in.front_from_push;
         rsp_ff.push_data       <= rsp_in.push_data;
      end
   end

   assign rsp_ctl = rsp_ff;

endmodule

@@ sv/double_ended_queue_unit.sv @@
// Top level of the bounded double-ended queue: control plus entry storage.
// Depends on deq_pkg, deq_ram and deq_ctrl.
//
// A bounded double-ended queue of signed words in a circular store of
// deq_pkg::DEPTH entries. Raise start with req_mode and req_push_value; the
// word is taken at a rising edge where start is high and busy is low. Busy
// is high only in the first cycle after reset, so from then on one word is
// taken every cycle. Each word gives exactly one result, shown for a single
// cycle with rsp_valid high, in the cycle right after acceptance, behind the
// registered read of the entry store. There is no backpressure
// on the result side; sample rsp_* whenever rsp_valid is high. A pop on an
// empty queue reports status 1 and a push on a full queue reports status 2;
// both leave the queue unchanged. Codes above peek behave as peek.
module double_ended_queue_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_mode,
   input  logic signed [31:0] req_push_value,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_popped_value,
   output logic signed [31:0] rsp_front_value,
   output logic [4:0]         rsp_entry_total,
   output logic               rsp_is_empty,
   output logic [1:0]         rsp_status
);

   deq_pkg::mem_cmd_type                   mem_cmd;
   deq_pkg::rsp_ctl_type                   rsp_ctl;
   logic        [deq_pkg::DATA_WIDTH-1:0]  push_data;
   logic        [deq_pkg::DATA_WIDTH-1:0]  pop_data;
   logic        [deq_pkg::DATA_WIDTH-1:0]  front_data;
   logic signed [deq_pkg::DATA_WIDTH-1:0]  popped_word;
   logic signed [deq_pkg::DATA_WIDTH-1:0]  front_word;
   logic                                   now_empty;

   // Keep only the low data bits of the pushed value.
   assign push_data = deq_pkg::DATA_WIDTH'(req_push_value);

   deq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_mode (req_mode),
      .req_data (push_data),
      .mem_cmd  (mem_cmd),
      .rsp_ctl  (rsp_ctl)
   );

   // Port a returns the popped entry, port b the entry at the new front.
   deq_ram #(
      .WIDTH (deq_pkg::DATA_WIDTH),
      .DEPTH (deq_pkg::DEPTH)
   ) u_store (
      .clock     (clock),
      .wr_en     (mem_cmd.wr_en),
      .wr_addr   (mem_cmd.wr_addr),
      .wr_data   (mem_cmd.wr_data),
      .rd_addr_a (mem_cmd.pop_addr),
      .rd_data_a (pop_data),
      .rd_addr_b (mem_cmd.front_addr),
      .rd_data_b (front_data)
   );

   assign now_empty = (rsp_ctl.count == '0);

   // Drop a failed pop, and the front of an empty queue, to zero; take the front
   // from the pushed word when the push itself became the front, since the store write lands too late.
   always_comb begin
      popped_word = rsp_ctl.pop_hit ? pop_data : '0;
      if (now_empty) begin
         front_word = '0;
      end else if (rsp_ctl.front_from_push) begin
         front_word = rsp_ctl.push_data;
      end else begin
         front_word = front_data;
      end
   end

   // Sign-extend the stored words to the port width.
   assign rsp_valid        = rsp_ctl.valid;
   assign rsp_popped_value = deq_pkg::VAL_W'(popped_word);
   assign rsp_front_value  = deq_pkg::VAL_W'(front_word);
   assign rsp_entry_total  = deq_pkg::TOTAL_W'(rsp_ctl.count);
   assign rsp_is_empty     = now_empty;
   assign rsp_status       = rsp_ctl.status;

endmodule
